// ----- hdl/tcw_pkg.sv -----
// Shared types and constants for the text console writer.
`timescale 1ns / 1ps
`default_nettype none
package tcw_pkg;

  // Fixed field widths
  localparam int POS_W  = 11;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = 16;
  localparam int IDX_W  = 11;

  // Character and attribute codes
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_TEXT_ATTR = 1'b0;  // register index, from paddr[2]

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    CMD_PUT  = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    OP_PUT_CHAR,
    OP_NEWLINE,
    OP_READ,
    OP_READ_NONE
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ_WAIT,
    ST_SCROLL_COPY,
    ST_SCROLL_FILL
  } back_state_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_position;
    logic [CELL_W-1:0] cell_word;
  } out_item_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } q_entry_t;

  // Front to back: head of the queue
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } fe_queue_t;

  // Back to front: status
  typedef struct packed {
    logic clearing;
    logic pop;
  } bk_status_t;

endpackage
`default_nettype wire

// ----- hdl/tcw_front.sv -----
// Front end: accepts items, classifies them and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module tcw_front import tcw_pkg::*; #(
  parameter int CELL_COUNT = 2000
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire in_item_t   in_item,
  output fe_queue_t       q_head,
  input  wire bk_status_t bk_status
);

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int EXT_W  = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  q_entry_t            entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     count_r, count_nxt;
  logic                push, pop;
  q_entry_t            new_entry;
  logic [EXT_W-1:0]    idx_ext;

  // Classify the incoming item
  always_comb begin
    idx_ext              = EXT_W'(in_item.cell_index);
    new_entry.char_code  = in_item.char_code;
    new_entry.cell_index = in_item.cell_index;
    if (in_item.cmd == CMD_PUT) begin
      new_entry.op = (in_item.char_code == NEWLINE_CHAR) ? OP_NEWLINE : OP_PUT_CHAR;
    end else begin
      new_entry.op = (idx_ext < EXT_W'(CELL_COUNT)) ? OP_READ : OP_READ_NONE;
    end
  end

  // Queue control
  assign busy  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH)) || bk_status.clearing;
  assign push  = start && !busy;
  assign pop   = bk_status.pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= new_entry;
    end
  end

  assign q_head.valid = (count_r != '0);
  assign q_head.entry = entries_r[rd_ptr_r];

endmodule
`default_nettype wire

// ----- hdl/tcw_back.sv -----
// Back end: screen memory, cursor, scroll sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
module tcw_back import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [ATTR_W-1:0] attr,
  input  wire fe_queue_t         q_head,
  output bk_status_t             bk_status,
  output logic                   out_valid,
  output out_item_t              out_item
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int COPY_N     = CELL_COUNT - COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int EXT_W      = (ADDR_W > POS_W) ? ADDR_W : POS_W;

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rdata_r;

  back_state_t       state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [CELL_W-1:0] blank_cell;
  logic [ADDR_W-1:0] pos;
  logic [ADDR_W-1:0] cur_nxt;
  logic [EXT_W-1:0]  cur_ext;
  logic [EXT_W-1:0]  idx_ext;
  logic              do_newline;
  logic              emit;
  logic [CELL_W-1:0] word_nxt;
  logic              pop;

  assign blank_cell = {attr, BLANK_CHAR};
  assign pos        = base_r + ADDR_W'(col_r);
  assign idx_ext    = EXT_W'(q_head.entry.cell_index);

  // Sequencer: next state, memory control and result
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    base_nxt      = base_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r;
    mem_wdata     = blank_cell;
    mem_raddr     = cnt_r + ADDR_W'(COLUMNS);
    do_newline    = 1'b0;
    emit          = 1'b0;
    word_nxt      = '0;
    pop           = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = {RESET_ATTR, BLANK_CHAR};
        if (cnt_r == ADDR_W'(CELL_COUNT - 1)) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (q_head.valid) begin
          pop = 1'b1;
          case (q_head.entry.op)
            OP_PUT_CHAR: begin
              mem_we    = 1'b1;
              mem_waddr = pos;
              mem_wdata = {attr, q_head.entry.char_code};
              if (col_r == COL_W'(COLUMNS - 1)) begin
                do_newline = 1'b1;
              end else begin
                col_nxt = col_r + 1'b1;
                emit    = 1'b1;
              end
            end
            OP_NEWLINE: begin
              do_newline = 1'b1;
            end
            OP_READ: begin
              mem_raddr = idx_ext[ADDR_W-1:0];
              state_nxt = ST_READ_WAIT;
            end
            OP_READ_NONE: begin
              emit = 1'b1;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
          // Newline, scrolling when on the bottom row
          if (do_newline) begin
            col_nxt = '0;
            if (row_r == ROW_W'(ROWS - 1)) begin
              state_nxt = ST_SCROLL_COPY;
              cnt_nxt   = '0;
            end else begin
              row_nxt  = row_r + 1'b1;
              base_nxt = base_r + ADDR_W'(COLUMNS);
              emit     = 1'b1;
            end
          end
        end
      end
      ST_READ_WAIT: begin
        emit      = 1'b1;
        word_nxt  = rdata_r;
        state_nxt = ST_IDLE;
      end
      ST_SCROLL_COPY: begin
        // read one row ahead, write the previous read back one row up
        if (cnt_r != '0) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_r - 1'b1;
          mem_wdata = rdata_r;
        end
        if (cnt_r == ADDR_W'(COPY_N)) begin
          state_nxt = ST_SCROLL_FILL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SCROLL_FILL: begin
        mem_we = 1'b1;
        if (cnt_r == ADDR_W'(CELL_COUNT - 1)) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Result register
    cur_nxt       = base_nxt + ADDR_W'(col_nxt);
    cur_ext       = EXT_W'(cur_nxt);
    out_valid_nxt = emit;
    out_item_nxt  = out_item_r;
    if (emit) begin
      out_item_nxt.cursor_position = cur_ext[POS_W-1:0];
      out_item_nxt.cell_word       = word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  // Screen memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  assign bk_status.clearing = (state_r == ST_CLEAR);
  assign bk_status.pop      = pop;
  assign out_valid          = out_valid_r;
  assign out_item           = out_item_r;

  // Checks
  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r < COL_W'(COLUMNS - 1)) || (col_r == COL_W'(COLUMNS - 1)))
    else $error("cursor column out of range");

  a_base_matches_row: assert property (@(posedge clk) disable iff (!rst_n)
    base_r == ADDR_W'(row_r * COLUMNS))
    else $error("row base out of step with cursor row");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (q_head.valid && state_r == ST_IDLE))
    else $error("queue popped without a waiting item");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |=> !out_valid_r)
    else $error("result issued during clearing pass");

  a_scroll_ends_on_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCROLL_FILL && state_nxt == ST_IDLE) |->
      (row_r == ROW_W'(ROWS - 1) && col_r == '0))
    else $error("scroll finished with cursor off the bottom row");

endmodule
`default_nettype wire

// ----- hdl/text_console_writer.sv -----
// Top level of the text console writer: configuration register and channel wiring.
//
// Usage:
//   Items enter on in_item and are accepted at a clock edge with start high and
//   busy low. A put item (cmd 0) stores a character at the cursor with the
//   current text attribute, or moves to the next line for a newline; a read item
//   (cmd 1) returns one screen cell. Every item gives one result on out_item,
//   marked by out_valid for exactly one cycle; the receiver cannot stall it.
//   Items wait in a two-entry queue and results keep item order; busy rises
//   only when that queue is full or while the screen is being cleared.
//   Each result comes from the result register once the item has left the queue;
//   a read also passes the registered read port of the screen memory. Throughput:
//   one put or newline per cycle while no scroll runs; a read holds the back end
//   in its read-wait state, though the queue still takes new items meanwhile.
//   A newline or line wrap on the bottom row scrolls the screen, one cell per
//   cycle through the single read and single write port of the screen memory.
//   After reset a clearing pass writes blank cells, one per cycle; busy stays high.
//   The attribute register (address 0, reset 0x0F) is written over the APB
//   port; the user must write it only while the block is idle, since the block
//   itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_item_t              in_item,
  output logic                       out_valid,
  output out_item_t                  out_item,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready
);

  logic [ATTR_W-1:0] attr_r, attr_nxt;
  logic              attr_sel;
  fe_queue_t         q_head;
  bk_status_t        bk_status;

  // Attribute register
  assign attr_sel = (paddr[2] == REG_TEXT_ATTR);
  assign pready   = 1'b1;

  always_comb begin
    attr_nxt = attr_r;
    if (psel && penable && pwrite && pready && attr_sel) begin
      attr_nxt = pwdata[ATTR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= RESET_ATTR;
    end else begin
      attr_r <= attr_nxt;
    end
  end

  assign prdata = attr_sel ? CFG_DATA_W'(attr_r) : '0;

  tcw_front #(
    .CELL_COUNT (ROWS * COLUMNS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .q_head    (q_head),
    .bk_status (bk_status)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .attr      (attr_r),
    .q_head    (q_head),
    .bk_status (bk_status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ----- tb/sv/console_checker.sv -----
// Checker for the text console writer: predicts each result and compares it with the block.
`timescale 1ns / 1ps
module console_checker import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic                  busy,
  input  wire in_item_t              in_item,
  input  wire logic                  out_valid,
  input  wire out_item_t             out_item,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic                  pready,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  input  wire logic [CFG_DATA_W-1:0] prdata,
  output int                         fail_count,
  output int                         outstanding
);

  localparam int CELLS = ROWS * COLUMNS;

  // Predicted console state
  logic [CELL_W-1:0] screen [CELLS];
  int unsigned       cur_row;
  int unsigned       cur_col;
  logic [ATTR_W-1:0] text_attr;

  out_item_t             expected_results [$];
  out_item_t             want;
  logic [CFG_DATA_W-1:0] rd_want;
  int                    mismatches = 0;

  function automatic void clear_console();
    for (int i = 0; i < CELLS; i++) screen[i] = {RESET_ATTR, BLANK_CHAR};
    cur_row   = 0;
    cur_col   = 0;
    text_attr = RESET_ATTR;
  endfunction

  // Column 0 of the next row; below the last row everything moves up one
  function automatic void next_row();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = {text_attr, BLANK_CHAR};
      cur_row = ROWS - 1;
    end
  endfunction

  // Apply one item to the predicted console and return its result
  function automatic out_item_t console_step(input in_item_t it);
    out_item_t   res;
    int unsigned pos;
    res.cell_word = '0;
    if (it.cmd == CMD_PUT) begin
      if (it.char_code == NEWLINE_CHAR) begin
        next_row();
      end else begin
        pos = cur_row * COLUMNS + cur_col;
        if (pos < CELLS) screen[pos] = {text_attr, it.char_code};
        cur_col++;
        // writing the last column wraps like a newline
        if (cur_col >= COLUMNS) next_row();
      end
    end else if (it.cell_index < CELLS) begin
      res.cell_word = screen[it.cell_index];
    end
    res.cursor_position = POS_W'(cur_row * COLUMNS + cur_col);
    return res;
  endfunction

  // Compare results, follow register writes, predict accepted items
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_console();
      expected_results.delete();
      outstanding <= 0;
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: cursor_position %0d cell_word 0x%04h",
                 out_item.cursor_position, out_item.cell_word);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_item.cursor_position !== want.cursor_position) begin
            $error("cursor_position: expected %0d, got %0d",
                   want.cursor_position, out_item.cursor_position);
            mismatches++;
          end
          if (out_item.cell_word !== want.cell_word) begin
            $error("cell_word: expected 0x%04h, got 0x%04h", want.cell_word, out_item.cell_word);
            mismatches++;
          end
        end
      end
      // Read data shows the attribute register, zero elsewhere
      rd_want = (paddr[2] == REG_TEXT_ATTR) ? CFG_DATA_W'(text_attr) : '0;
      if (prdata !== rd_want) begin
        $error("prdata: expected 0x%08h, got 0x%08h", rd_want, prdata);
        mismatches++;
      end
      if (psel && penable && pwrite && pready && paddr[2] == REG_TEXT_ATTR)
        text_attr = pwdata[ATTR_W-1:0];
      if (start && !busy) expected_results.push_back(console_step(in_item));
      outstanding <= expected_results.size();
    end
    fail_count <= mismatches;
  end

endmodule

// ----- tb/sv/text_console_writer_tb.sv -----
// Testbench top for the text console writer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int COLUMNS        = 80;
  localparam int ROWS           = 25;
  localparam int CELLS          = ROWS * COLUMNS;
  localparam int RANDOM_ITEMS   = 1450;
  localparam int SCROLL_CYCLES  = CELLS + 100;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [CFG_ADDR_W-1:0] ATTR_ADDR = {REG_TEXT_ATTR, 2'b00};

  logic                  clk     = 1'b0;
  logic                  rst_n   = 1'b0;
  logic                  start   = 1'b0;
  in_item_t              in_item = '0;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic                  busy;
  logic                  out_valid;
  out_item_t             out_item;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    fail_count;
  int                    outstanding;

  int gap_pct = 0;
  int sent    = 0;
  int idle_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  text_console_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  console_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .pready(pready), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  // Watchdog: too long with no item accepted, no result and no register write
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_item_t put_item(input logic [CHAR_W-1:0] ch);
    in_item_t it;
    it.cmd        = CMD_PUT;
    it.char_code  = ch;
    it.cell_index = IDX_W'($urandom);  // ignored by a put
    return it;
  endfunction

  function automatic in_item_t read_item(input logic [IDX_W-1:0] idx,
                                         input logic [CHAR_W-1:0] ch);
    in_item_t it;
    it.cmd        = CMD_READ;
    it.char_code  = ch;  // ignored by a read
    it.cell_index = idx;
    return it;
  endfunction

  // Printable or not, anything but a newline
  function automatic logic [CHAR_W-1:0] text_char();
    logic [CHAR_W-1:0] ch;
    do ch = CHAR_W'($urandom); while (ch == NEWLINE_CHAR);
    return ch;
  endfunction

  // Reads favour the top and bottom rows, with some beyond the screen
  function automatic logic [IDX_W-1:0] pick_cell();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50)      return IDX_W'($urandom_range(0, CELLS - 1));
    else if (r < 75) return IDX_W'($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1));
    else if (r < 88) return IDX_W'($urandom_range(0, 2 * COLUMNS - 1));
    else if (r < 95) return IDX_W'($urandom_range(CELLS, 2 ** IDX_W - 1));
    else             return IDX_W'($urandom);
  endfunction

  // Offer one item, after a random gap, and hold it until accepted
  task automatic issue(input in_item_t it);
    if ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  // A run of characters with reads mixed in, optionally closed by a newline
  task automatic write_line(input int len, input bit with_newline);
    for (int k = 0; k < len; k++) begin
      issue(put_item(text_char()));
      if ($urandom_range(0, 99) < 35) issue(read_item(pick_cell(), CHAR_W'($urandom)));
    end
    if (with_newline) issue(put_item(NEWLINE_CHAR));
  endtask

  // Wait for every result, then for a possible scroll to finish
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SCROLL_CYCLES) @(posedge clk);
  endtask

  task automatic write_attr(input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ATTR_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int                r;
    int                target;
    int                gap_base;
    logic [ATTR_W-1:0] attr;
    in_item_t          noise;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: blank screen after clearing, range edges, extreme characters
    gap_pct = 0;
    issue(read_item(IDX_W'(0), 8'h00));
    issue(read_item(IDX_W'(CELLS - 1), 8'h00));
    issue(read_item(IDX_W'(CELLS), 8'h00));
    issue(read_item(IDX_W'(2 ** IDX_W - 1), 8'hFF));
    issue(put_item(8'h00));
    issue(put_item(8'hFF));
    issue(put_item(8'h41));
    issue(read_item(IDX_W'(0), NEWLINE_CHAR));
    issue(read_item(IDX_W'(1), 8'h00));
    issue(read_item(IDX_W'(2), 8'h00));
    issue(put_item(NEWLINE_CHAR));
    issue(put_item(8'h55));
    issue(put_item(8'hAA));
    issue(read_item(IDX_W'(COLUMNS), 8'h00));
    issue(read_item(IDX_W'(COLUMNS + 1), 8'h00));
    issue(put_item(NEWLINE_CHAR));
    issue(put_item(NEWLINE_CHAR));
    issue(put_item(BLANK_CHAR));
    issue(read_item(IDX_W'(3 * COLUMNS), 8'hFF));
    issue(read_item(IDX_W'(3 * COLUMNS + 1), 8'h00));

    // Random phases, each writing an attribute and choosing sender gaps
    for (int p = 0; p < 4; p++) begin
      settle();
      case (p)
        0:       attr = 8'hFF;
        1:       attr = 8'h00;
        default: attr = ATTR_W'($urandom);
      endcase
      write_attr({(CFG_DATA_W - ATTR_W)'($urandom), attr} |
                 (p == 0 ? 32'hFFFF_FF00 : 32'h0));
      gap_base = (p == 1) ? 79 : (p == 3) ? 7 : 0;
      target   = sent + RANDOM_ITEMS / 4;
      while (sent < target) begin
        gap_pct = ($urandom_range(0, 3) == 0) ? 0 : gap_base;
        r = $urandom_range(0, 99);
        if (r < 10) begin
          noise.cmd        = cmd_t'($urandom_range(0, 1));
          noise.char_code  = CHAR_W'($urandom);
          noise.cell_index = IDX_W'($urandom);
          issue(noise);
        end else if (r < 55) begin
          write_line($urandom_range(0, 4), 1'b1);
        end else if (r < 80) begin
          write_line($urandom_range(5, 40), 1'b1);
        end else if (r < 92) begin
          write_line(COLUMNS - 1, 1'b1);
        end else begin
          write_line(COLUMNS, 1'b0);  // fills the row and wraps
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
